@@ design/rtse_pkg.sv @@
`default_nettype none

package rtse_pkg;

  // channel widths
  localparam int CH_W   = 25;
  localparam int BYTE_W = 8;

  // default number of fraction bits of the input channels
  localparam int FRAC_BITS_DEF = 16;

  // luminance weights in Q16 (0.2126, 0.7152, 0.0722), summing to one
  localparam int WGT_W = 17;
  localparam logic signed [WGT_W-1:0] W_RED   = 17'sd13933;
  localparam logic signed [WGT_W-1:0] W_GREEN = 17'sd46871;
  localparam logic signed [WGT_W-1:0] W_BLUE  = 17'sd4732;
  localparam int WGT_FRAC = 16;

  // weighted channel and luminance sum widths
  localparam int PROD_W = CH_W + WGT_W;
  localparam int LUM_W  = PROD_W + 1;

  // scaled linear value: Q20, one extra bit to hold exactly one
  localparam int LIN_FRAC = 20;
  localparam int LIN_W    = LIN_FRAC + 1;

  // quotient bits per pass of the divider, and steps of the byte search
  localparam int DIV_STEPS  = LIN_FRAC;
  localparam int SRCH_STEPS = BYTE_W;
  localparam int THR_N      = 2 ** BYTE_W;

  typedef logic [THR_N-1:0][LIN_W-1:0] thr_tab_t;

  // fifth power in Q30, truncating each product
  function automatic longint unsigned pow5_q30(input longint unsigned r);
    longint unsigned p;
    p = (r * r) >> 30;
    p = (p * r) >> 30;
    p = (p * r) >> 30;
    p = (p * r) >> 30;
    return p;
  endfunction

  // sRGB decision thresholds in Q20: byte = number of entries 1 to 255 at or below lin
  function automatic thr_tab_t enc_thr_build();
    thr_tab_t        tab;
    longint unsigned odd;
    longint unsigned num;
    longint unsigned t;
    longint unsigned s;
    longint unsigned x;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    tab = '0;
    for (int k = 1; k < THR_N; k++) begin
      odd = longint'(2 * k - 1);
      if (k <= 10) begin
        // linear segment, threshold is y / 12.92
        tab[k] = LIN_W'((((odd * 10) << 20) + 65891) / 65892);
      end else begin
        // power segment, x = s^(6/5) with s = ((y + 0.055) / 1.055)^2
        num = odd * 1000 + 28050;
        t   = (num << 30) / 538050;
        s   = (t * t) >> 30;
        lo  = 0;
        hi  = 64'd1 << 30;
        for (int i = 0; i < 32; i++) begin
          if (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            if (pow5_q30(mid) <= s) begin
              lo = mid;
            end else begin
              hi = mid - 1;
            end
          end
        end
        x      = (s * lo) >> 30;
        tab[k] = LIN_W'((x + 1023) >> 10);
      end
    end
    return tab;
  endfunction

  localparam thr_tab_t ENC_THR = enc_thr_build();

endpackage

`default_nettype wire

@@ design/rtse_in_if.sv @@
`default_nettype none

interface rtse_in_if;
  import rtse_pkg::*;

  logic                   valid;
  logic                   ready;
  logic signed [CH_W-1:0] red_in;
  logic signed [CH_W-1:0] green_in;
  logic signed [CH_W-1:0] blue_in;

  modport source(output valid, output red_in, output green_in, output blue_in, input ready);
  modport sink(input valid, input red_in, input green_in, input blue_in, output ready);
endinterface

`default_nettype wire

@@ design/rtse_out_if.sv @@
`default_nettype none

interface rtse_out_if;
  import rtse_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] red_out;
  logic [BYTE_W-1:0] green_out;
  logic [BYTE_W-1:0] blue_out;

  modport source(output valid, output red_out, output green_out, output blue_out, input ready);
  modport sink(input valid, input red_out, input green_out, input blue_out, output ready);
endinterface

`default_nettype wire

@@ design/reinhard_tonemap_srgb_encode.sv @@
// channel   direction  payload                              handshake
// in_ch     input      red_in, green_in, blue_in (s25 Q)    valid / ready
// out_ch    output     red_out, green_out, blue_out (u8)    valid / ready
//
// one pixel per cycle sustained while the skid register is free; an input
// reaches output valid through 33 register stages (3 luminance, 21 divider,
// 8 search, output register). the divider retires one quotient bit per stage.
// rst_n is synchronous and clears valid bits only; payload is not reset.
// the pipeline stalls as a whole only when the skid register is full, so
// in_ch.ready is a register and an input is still taken while a result waits.
`default_nettype none

module reinhard_tonemap_srgb_encode #(
  parameter int FRAC_BITS = rtse_pkg::FRAC_BITS_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  rtse_in_if.sink    in_ch,
  rtse_out_if.source out_ch
);
  import rtse_pkg::*;

  // denominator width: holds 2^(FRAC_BITS+16) plus the largest luminance
  localparam int BASE_SH = FRAC_BITS + WGT_FRAC;
  localparam int DW      = ((BASE_SH > PROD_W - 2) ? BASE_SH : (PROD_W - 2)) + 2;
  localparam logic [DW-1:0] BASE = DW'(64'd1 << BASE_SH);
  localparam logic signed [LUM_W-1:0] EPS =
    LUM_W'((64'd1 << BASE_SH) / 64'd1000000);
  // channel shifted to compare against the denominator (32 - 16)
  localparam int NUM_SH = WGT_FRAC;

  // stage positions
  localparam int ST_MUL   = 0;
  localparam int ST_SUM   = 1;
  localparam int ST_DEN   = 2;
  localparam int ST_DIV0  = 3;
  localparam int ST_SRCH0 = ST_DIV0 + DIV_STEPS + 1;
  localparam int N_ST     = ST_SRCH0 + SRCH_STEPS;

  logic [N_ST-1:0] vld_r;
  logic            en;
  logic            out_vld_r;
  logic            skid_vld_r;
  logic            pop;
  logic            leave;

  logic signed [CH_W-1:0]   chan_in [3];
  logic signed [CH_W-1:0]   c0_r [3];
  logic signed [CH_W-1:0]   c1_r [3];
  logic signed [CH_W-1:0]   c2_r [3];
  logic signed [PROD_W-1:0] prod0_r [3];
  logic signed [LUM_W-1:0]  lum1_r;
  logic [DW-1:0]            den2_r;

  logic [DW-1:0]       den_r  [DIV_STEPS];
  logic [DW-1:0]       rem_r  [DIV_STEPS][3];
  logic [LIN_FRAC-1:0] quo_r  [DIV_STEPS+1][3];
  logic [2:0]          zero_r [DIV_STEPS+1];
  logic [2:0]          one_r  [DIV_STEPS+1];

  logic [LIN_W-1:0]  lin_r [SRCH_STEPS-1][3];
  logic [BYTE_W-1:0] cnt_r [SRCH_STEPS][3];

  logic [BYTE_W-1:0] out_px_r  [3];
  logic [BYTE_W-1:0] skid_px_r [3];

  assign chan_in[0] = in_ch.red_in;
  assign chan_in[1] = in_ch.green_in;
  assign chan_in[2] = in_ch.blue_in;

  // whole pipeline advances while the skid register is free
  assign en          = !skid_vld_r;
  assign in_ch.ready = en;
  assign pop         = out_vld_r && out_ch.ready;
  assign leave       = vld_r[N_ST-1] && en;

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[N_ST-2:0], in_ch.valid};
    end
  end

  // weighted channels
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        c0_r[c] <= chan_in[c];
      end
      prod0_r[0] <= PROD_W'(chan_in[0]) * W_RED;
      prod0_r[1] <= PROD_W'(chan_in[1]) * W_GREEN;
      prod0_r[2] <= PROD_W'(chan_in[2]) * W_BLUE;
    end
  end

  // luminance sum
  always_ff @(posedge clk) begin
    if (en) begin
      c1_r   <= c0_r;
      lum1_r <= LUM_W'(prod0_r[0]) + LUM_W'(prod0_r[1]) + LUM_W'(prod0_r[2]);
    end
  end

  // denominator, one plus luminance when above epsilon
  always_ff @(posedge clk) begin
    if (en) begin
      c2_r   <= c1_r;
      den2_r <= (lum1_r > EPS) ? (BASE + DW'(lum1_r)) : BASE;
    end
  end

  // divider setup: clamp flags and initial remainder
  for (genvar c = 0; c < 3; c++) begin : g_init
    logic [DW-1:0] num_hi;
    assign num_hi = DW'(c2_r[c][CH_W-2:0]) << NUM_SH;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[0][c]  <= num_hi;
        quo_r[0][c]  <= '0;
        zero_r[0][c] <= c2_r[c][CH_W-1] || (c2_r[c] == '0);
        one_r[0][c]  <= num_hi >= den2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_r[0] <= den2_r;
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_div
    for (genvar c = 0; c < 3; c++) begin : g_ch
      logic [DW:0] trial;
      logic        ge;
      assign trial = {rem_r[j-1][c], 1'b0};
      assign ge    = trial >= {1'b0, den_r[j-1]};

      always_ff @(posedge clk) begin
        if (en) begin
          quo_r[j][c]  <= {quo_r[j-1][c][LIN_FRAC-2:0], ge};
          zero_r[j][c] <= zero_r[j-1][c];
          one_r[j][c]  <= one_r[j-1][c];
        end
      end

      if (j < DIV_STEPS) begin : g_rem
        always_ff @(posedge clk) begin
          if (en) begin
            rem_r[j][c] <= ge ? DW'(trial - {1'b0, den_r[j-1]}) : DW'(trial);
          end
        end
      end
    end

    if (j < DIV_STEPS) begin : g_den
      always_ff @(posedge clk) begin
        if (en) begin
          den_r[j] <= den_r[j-1];
        end
      end
    end
  end

  // threshold search, one byte bit per stage, msb first
  for (genvar s = 0; s < SRCH_STEPS; s++) begin : g_srch
    for (genvar c = 0; c < 3; c++) begin : g_ch
      logic [LIN_W-1:0]  lin_src;
      logic [BYTE_W-1:0] cnt_src;
      logic [BYTE_W-1:0] cand;

      if (s == 0) begin : g_first
        // clamp to [0,1] on the divider result
        always_comb begin
          if (zero_r[DIV_STEPS][c]) begin
            lin_src = '0;
          end else if (one_r[DIV_STEPS][c]) begin
            lin_src = LIN_W'(1) << LIN_FRAC;
          end else begin
            lin_src = {1'b0, quo_r[DIV_STEPS][c]};
          end
        end
        assign cnt_src = '0;
      end else begin : g_next
        assign lin_src = lin_r[s-1][c];
        assign cnt_src = cnt_r[s-1][c];
      end

      assign cand = cnt_src | (BYTE_W'(1) << (BYTE_W - 1 - s));

      always_ff @(posedge clk) begin
        if (en) begin
          cnt_r[s][c] <= (lin_src >= ENC_THR[cand]) ? cand : cnt_src;
        end
      end

      if (s < SRCH_STEPS - 1) begin : g_lin
        always_ff @(posedge clk) begin
          if (en) begin
            lin_r[s][c] <= lin_src;
          end
        end
      end
    end
  end

  // output register with skid register behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (pop) begin
        skid_vld_r <= 1'b0;
      end
    end else if (leave) begin
      if (out_vld_r && !pop) begin
        skid_vld_r <= 1'b1;
      end else begin
        out_vld_r <= 1'b1;
      end
    end else if (pop) begin
      out_vld_r <= 1'b0;
    end
  end

  // output and skid payload
  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (pop) begin
        out_px_r <= skid_px_r;
      end
    end else if (leave) begin
      if (out_vld_r && !pop) begin
        skid_px_r <= cnt_r[SRCH_STEPS-1];
      end else begin
        out_px_r <= cnt_r[SRCH_STEPS-1];
      end
    end
  end

  assign out_ch.valid     = out_vld_r;
  assign out_ch.red_out   = out_px_r[0];
  assign out_ch.green_out = out_px_r[1];
  assign out_ch.blue_out  = out_px_r[2];

endmodule

`default_nettype wire
